>>> src/arabic_codepage_to_utf8_assert.svh
// assertion macros shared by the transcoder rtl
`ifndef ARABIC_CODEPAGE_TO_UTF8_ASSERT_SVH
`define ARABIC_CODEPAGE_TO_UTF8_ASSERT_SVH

`ifndef SYNTH
// check that is switched off while reset is held
`define ACU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds while reset is held
`define ACU_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ACU_ASSERT(label, clk, rst_n, prop, msg)
`define ACU_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> src/acp2u_pkg.sv
// types, code constants and lookup tables of the code page transcoder
package acp2u_pkg;

  localparam logic [7:0] ASCII_MAX    = 8'h7F;
  localparam logic [7:0] TBL_LO_BASE  = 8'h80;
  localparam logic [7:0] TBL_LO_END   = 8'hAF;
  localparam logic [7:0] TBL_HI_BASE  = 8'hB0;
  localparam logic [7:0] TBL_HI_START = 8'hE0;
  localparam logic [7:0] TBL_HI_END   = 8'hFE;
  localparam logic [7:0] LAM_ALEF     = 8'hF2;
  localparam logic [7:0] SPACE_CODE   = 8'hFF;
  localparam logic [7:0] ASCII_SPACE  = 8'h20;

  localparam logic [6:0] LAM_IDX  = 7'd65;  // iran system 0xF1
  localparam logic [6:0] ALEF_IDX = 7'd17;  // iran system 0x91

  localparam int MAX_BYTES = 4;
  localparam int BIDX_W    = $clog2(MAX_BYTES);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic CP_IRAN_SYSTEM = 1'b0;
  localparam logic CP_WIN1256     = 1'b1;

  // one classified source byte: its utf-8 bytes in send order
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [BIDX_W-1:0]         last_idx;
    logic                      text_last;
  } entry_t;

  // windows-1256 byte to iran system code
  function automatic logic [7:0] win1256_to_iran(input logic [7:0] b);
    logic [7:0] c;
    unique case (b) inside
      8'h81:                      c = 8'h94;
      8'h8D:                      c = 8'h9C;
      8'h8E:                      c = 8'hA6;
      8'h90:                      c = 8'hEF;
      8'h98, 8'hDF:               c = 8'hED;
      8'hA1:                      c = 8'h8A;
      8'hAA:                      c = 8'hFB;
      8'hBF:                      c = 8'h8C;
      8'hC0, 8'hC9, 8'hE5:        c = 8'hF9;
      8'hC1:                      c = 8'h8F;
      8'hC2, 8'hC3, 8'hC5, 8'hC7: c = 8'h91;
      8'hC4, 8'hE6:               c = 8'hF8;
      8'hC6, 8'hEC, 8'hED:        c = 8'hFD;
      8'hC8:                      c = 8'h92;
      8'hCA:                      c = 8'h96;
      8'hCB:                      c = 8'h98;
      8'hCC:                      c = 8'h9A;
      8'hCD:                      c = 8'h9E;
      8'hCE:                      c = 8'hA0;
      8'hCF:                      c = 8'hA2;
      8'hD0:                      c = 8'hA3;
      8'hD1, 8'h9A:               c = 8'hA4;
      8'hD2:                      c = 8'hA5;
      8'hD3:                      c = 8'hA7;
      8'hD4:                      c = 8'hA9;
      8'hD5:                      c = 8'hAB;
      8'hD6:                      c = 8'hAD;
      8'hD8:                      c = 8'hAF;
      8'hD9:                      c = 8'hE0;
      8'hDA:                      c = 8'hE1;
      8'hDB:                      c = 8'hE5;
      8'hDC:                      c = 8'h8B;
      8'hDD:                      c = 8'hE9;
      8'hDE:                      c = 8'hEB;
      8'hE1:                      c = 8'hF1;
      8'hE3:                      c = 8'hF4;
      8'hE4:                      c = 8'hF6;
      default:                    c = SPACE_CODE;
    endcase
    return c;
  endfunction

  // two-byte utf-8 table, first byte in the upper half
  function automatic logic [15:0] utf8_pair(input logic [6:0] idx);
    logic [15:0] p;
    unique case (idx) inside
      7'd0:                     p = 16'hDBB0;
      7'd1:                     p = 16'hDBB1;
      7'd2:                     p = 16'hDBB2;
      7'd3:                     p = 16'hDBB3;
      7'd4:                     p = 16'hDBB4;
      7'd5:                     p = 16'hDBB5;
      7'd6:                     p = 16'hDBB6;
      7'd7:                     p = 16'hDBB7;
      7'd8:                     p = 16'hDBB8;
      7'd9:                     p = 16'hDBB9;
      7'd10:                    p = 16'hD88C;
      7'd11:                    p = 16'h2D00;
      7'd12:                    p = 16'hD89F;
      7'd13:                    p = 16'hD8A2;
      7'd14:                    p = 16'hD8A6;
      7'd15:                    p = 16'hD8A1;
      7'd16, 7'd17:             p = 16'hD8A7;
      7'd18, 7'd19:             p = 16'hD8A8;
      7'd20, 7'd21:             p = 16'hD9BE;
      7'd22, 7'd23:             p = 16'hD8AA;
      7'd24, 7'd25:             p = 16'hD8AB;
      7'd26, 7'd27:             p = 16'hD8AC;
      7'd28, 7'd29:             p = 16'hDA86;
      7'd30, 7'd31:             p = 16'hD8AD;
      7'd32, 7'd33:             p = 16'hD8AE;
      7'd34:                    p = 16'hD8AF;
      7'd35:                    p = 16'hD8B0;
      7'd36:                    p = 16'hD8B1;
      7'd37:                    p = 16'hD8B2;
      7'd38:                    p = 16'hDA98;
      7'd39, 7'd40:             p = 16'hD8B3;
      7'd41, 7'd42:             p = 16'hD8B4;
      7'd43, 7'd44:             p = 16'hD8B5;
      7'd45, 7'd46:             p = 16'hD8B6;
      7'd47:                    p = 16'hD8B7;
      7'd48:                    p = 16'hD8B8;
      7'd49, 7'd50, 7'd51, 7'd52: p = 16'hD8B9;
      7'd53, 7'd54, 7'd55, 7'd56: p = 16'hD8BA;
      7'd57, 7'd58:             p = 16'hD981;
      7'd59, 7'd60:             p = 16'hD982;
      7'd61, 7'd62:             p = 16'hDAA9;
      7'd63, 7'd64:             p = 16'hDAAF;
      7'd65, 7'd67:             p = 16'hD984;
      7'd66:                    p = 16'h0000;
      7'd68, 7'd69:             p = 16'hD985;
      7'd70, 7'd71:             p = 16'hD986;
      7'd72:                    p = 16'hD988;
      7'd73, 7'd74, 7'd75:      p = 16'hD987;
      7'd76, 7'd77, 7'd78:      p = 16'hD98A;
      default:                  p = 16'h2000;
    endcase
    return p;
  endfunction

endpackage

>>> src/acp2u_if.sv
// stream interfaces for source bytes and utf-8 bytes
interface acp2u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source(output valid, in_byte, in_last, input ready);
  modport sink(input valid, in_byte, in_last, output ready);
endinterface

interface acp2u_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       text_end;
  modport source(output valid, out_byte, run_last, text_end, input ready);
  modport sink(input valid, out_byte, run_last, text_end, output ready);
endinterface

>>> src/arabic_codepage_to_utf8.sv
// top level of the arabic code page to utf-8 transcoder
//
// converts one source byte per transfer on in_ch into one to four utf-8
// bytes on out_ch. cfg_wdata, written while cfg_we is high, picks the source
// code page: 0 for iran system, 1 for windows-1256 (reset value 0). ascii
// bytes pass unchanged; windows-1256 bytes are mapped to iran system codes
// first; iran system codes then go through a two-byte utf-8 table, lam-alef
// gives four bytes and anything unmapped gives a space. run_last marks the
// final utf-8 byte of each source byte and text_end the final byte of the
// source byte flagged with in_last. out_ch sends one byte per cycle while
// out_ch is ready. a source byte gives one utf-8 byte for ascii and spaces,
// two for most arabic letters, four for lam-alef. the front end classifies
// a byte in the cycle it is taken and writes it to a two-entry queue, so
// in_ch keeps taking a byte per cycle while the queue has room and the back
// end keeps sending while out_ch is ready. each entry is registered in the
// queue and then loaded into the output register, from which its first
// utf-8 byte shows on out_ch.
module arabic_codepage_to_utf8 (
  input  logic         clk,
  input  logic         rst_n,
  acp2u_in_if.sink     in_ch,
  acp2u_out_if.source  out_ch,
  input  logic         cfg_we,
  input  logic         cfg_wdata
);

  // front to queue
  logic              q_wr_valid;
  logic              q_wr_ready;
  acp2u_pkg::entry_t q_wr_entry;

  // queue to back
  logic              q_rd_valid;
  logic              q_rd_pop;
  acp2u_pkg::entry_t q_rd_entry;

  // remap and table lookup of each accepted byte
  acp2u_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_entry (q_wr_entry)
  );

  // decouples input stalls from output stalls
  acp2u_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(q_wr_valid),
    .wr_ready(q_wr_ready),
    .wr_entry(q_wr_entry),
    .rd_valid(q_rd_valid),
    .rd_pop  (q_rd_pop),
    .rd_entry(q_rd_entry)
  );

  // serializes each entry onto the registered output
  acp2u_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_valid(q_rd_valid),
    .rd_pop  (q_rd_pop),
    .rd_entry(q_rd_entry),
    .out_ch  (out_ch)
  );

endmodule

>>> src/acp2u_front.sv
// front end: code page register and classification of each source byte
module acp2u_front (
  input  logic                 clk,
  input  logic                 rst_n,
  acp2u_in_if.sink             in_ch,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  output logic                 wr_valid,
  input  logic                 wr_ready,
  output acp2u_pkg::entry_t    wr_entry
);

  logic page_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r <= acp2u_pkg::CP_IRAN_SYSTEM;
    end else if (cfg_we) begin
      page_r <= cfg_wdata;
    end
  end

  assign wr_valid    = in_ch.valid;
  assign in_ch.ready = wr_ready;

  always_comb begin
    logic [7:0]  code;
    logic [7:0]  offs;
    logic [15:0] pair;
    logic [15:0] lam;
    logic [15:0] alef;
    code = (page_r == acp2u_pkg::CP_WIN1256) ?
           acp2u_pkg::win1256_to_iran(in_ch.in_byte) : in_ch.in_byte;
    // one table read; low and high ranges differ only in base
    offs = (code <= acp2u_pkg::TBL_LO_END) ? code - acp2u_pkg::TBL_LO_BASE
                                           : code - acp2u_pkg::TBL_HI_BASE;
    pair = acp2u_pkg::utf8_pair(offs[6:0]);
    lam  = acp2u_pkg::utf8_pair(acp2u_pkg::LAM_IDX);
    alef = acp2u_pkg::utf8_pair(acp2u_pkg::ALEF_IDX);

    wr_entry           = '0;
    wr_entry.text_last = in_ch.in_last;
    if (in_ch.in_byte <= acp2u_pkg::ASCII_MAX) begin
      wr_entry.bytes[0] = in_ch.in_byte;
      wr_entry.last_idx = acp2u_pkg::BIDX_W'(0);
    end else if (code == acp2u_pkg::LAM_ALEF) begin
      wr_entry.bytes[0] = lam[15:8];
      wr_entry.bytes[1] = lam[7:0];
      wr_entry.bytes[2] = alef[15:8];
      wr_entry.bytes[3] = alef[7:0];
      wr_entry.last_idx = acp2u_pkg::BIDX_W'(acp2u_pkg::MAX_BYTES - 1);
    end else if (code <= acp2u_pkg::TBL_LO_END ||
                 (code >= acp2u_pkg::TBL_HI_START && code <= acp2u_pkg::TBL_HI_END)) begin
      wr_entry.bytes[0] = pair[15:8];
      wr_entry.bytes[1] = pair[7:0];
      wr_entry.last_idx = (pair[7:0] != 8'h00) ? acp2u_pkg::BIDX_W'(1)
                                               : acp2u_pkg::BIDX_W'(0);
    end else begin
      wr_entry.bytes[0] = acp2u_pkg::ASCII_SPACE;
      wr_entry.last_idx = acp2u_pkg::BIDX_W'(0);
    end
  end

endmodule

>>> src/acp2u_queue.sv
// short queue of classified entries between front and back
`include "arabic_codepage_to_utf8_assert.svh"

module acp2u_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  acp2u_pkg::entry_t    wr_entry,
  output logic                 rd_valid,
  input  logic                 rd_pop,
  output acp2u_pkg::entry_t    rd_entry
);

  acp2u_pkg::entry_t                mem [acp2u_pkg::QDEPTH];
  logic [acp2u_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [acp2u_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [acp2u_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                             push;
  logic                             pop;

  assign wr_ready = (count_r != acp2u_pkg::QCNT_W'(acp2u_pkg::QDEPTH));
  assign rd_valid = (count_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;
  assign rd_entry = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == acp2u_pkg::QPTR_W'(acp2u_pkg::QDEPTH - 1)) ?
                   '0 : wr_ptr_r + acp2u_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == acp2u_pkg::QPTR_W'(acp2u_pkg::QDEPTH - 1)) ?
                   '0 : rd_ptr_r + acp2u_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + acp2u_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - acp2u_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_entry;
    end
  end

  `ACU_ASSERT(a_q_count_bound, clk, rst_n, count_r <= acp2u_pkg::QCNT_W'(acp2u_pkg::QDEPTH), "queue count past depth")
  `ACU_ASSERT(a_q_ptr_gap, clk, rst_n, (count_r == '0 || count_r == acp2u_pkg::QCNT_W'(acp2u_pkg::QDEPTH)) |-> (wr_ptr_r == rd_ptr_r), "queue pointers out of step with count")

endmodule

>>> src/acp2u_back.sv
// back end: sends the bytes of each queued entry, one per cycle while out_ch is ready
`include "arabic_codepage_to_utf8_assert.svh"

module acp2u_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_valid,
  output logic                 rd_pop,
  input  acp2u_pkg::entry_t    rd_entry,
  acp2u_out_if.source          out_ch
);

  logic [acp2u_pkg::BIDX_W-1:0] k_r, k_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [7:0]                   out_byte_r;
  logic                         out_run_last_r;
  logic                         out_text_end_r;
  logic                         load;
  logic                         fin;

  assign load = rd_valid && (!out_valid_r || out_ch.ready);
  assign fin  = (k_r == rd_entry.last_idx);
  assign rd_pop = load && fin;

  always_comb begin
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      k_nxt         = fin ? '0 : k_r + acp2u_pkg::BIDX_W'(1);
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r     <= rd_entry.bytes[k_r];
      out_run_last_r <= fin;
      out_text_end_r <= fin && rd_entry.text_last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.run_last = out_run_last_r;
  assign out_ch.text_end = out_text_end_r;

  `ACU_ASSERT(a_k_within_entry, clk, rst_n, rd_valid |-> (k_r <= rd_entry.last_idx), "byte index past end of entry")
  `ACU_ASSERT(a_k_idle_zero, clk, rst_n, !rd_valid |-> (k_r == '0), "byte index left mid entry with queue empty")
  `ACU_ASSERT(a_end_on_run_last, clk, rst_n, (out_valid_r && out_text_end_r) |-> out_run_last_r, "text end off a run boundary")
  `ACU_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (!out_valid_r && k_r == '0), "back end not idle after reset")

endmodule
